// File: src/dmnc_pkg.sv
// ----------------------------------------------------------------------------
// dmnc_pkg
// Shared types and constants for the distributed mutex node controller.
// ----------------------------------------------------------------------------
package dmnc_pkg;

  localparam int unsigned MaxNodes   = 16;
  localparam int unsigned IdW        = $clog2(MaxNodes);
  localparam int unsigned StampW     = 32;
  localparam int unsigned HostCountW = 5;
  localparam int unsigned CountW     = 4;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 5;

  localparam logic [HostCountW-1:0] HostCountRst = HostCountW'(2);
  localparam logic [CountW-1:0]     CountMax     = '1;

  typedef enum logic [1:0] {
    OpAcquire = 2'd0,
    OpRelease = 2'd1,
    OpRequest = 2'd2,
    OpReply   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SendNone      = 2'd0,
    SendReply     = 2'd1,
    SendBroadcast = 2'd2
  } send_kind_e;

  typedef enum logic [1:0] {
    StsOk         = 2'd0,
    StsBadAcquire = 2'd1,
    StsBadRelease = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHostCount = 1'd0,
    CfgLocalId   = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StWalk
  } state_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic rel_more;
    logic more;
  } sts_t;

endpackage

// File: src/distributed_mutex_node_controller_top.sv
// ----------------------------------------------------------------------------
// distributed_mutex_node_controller_top
// One node of a Ricart-Agrawala lock with a Lamport clock.
//
//   channel   handshake                 payload
//   -------   -----------------------   ---------------------------------------
//   in        in_valid_i / in_stall_o   op, peer_id, peer_stamp
//   out       out_valid_o / out_stall_i send_kind, dest_id, send_stamp,
//                                       granted, status, last
//   cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An event is captured in the idle state, then run through the state update
// into the result register in the execute state. A release with deferred
// peers then sends each further reply from the bitmap walk. Output stalls
// hold the sequencer. Reset clears all node state; host_count resets to 2.
// ----------------------------------------------------------------------------
module distributed_mutex_node_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [dmnc_pkg::IdW-1:0]      peer_id_i,
  input  logic [dmnc_pkg::StampW-1:0]   peer_stamp_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    send_kind_o,
  output logic [dmnc_pkg::IdW-1:0]      dest_id_o,
  output logic [dmnc_pkg::StampW-1:0]   send_stamp_o,
  output logic                          granted_o,
  output logic [1:0]                    status_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dmnc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dmnc_pkg::CfgDataW-1:0] cfg_data_i
);

  dmnc_pkg::cmd_t cmd;
  dmnc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  dmnc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dmnc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (op_i),
    .peer_id_i    (peer_id_i),
    .peer_stamp_i (peer_stamp_i),
    .send_kind_o  (send_kind_o),
    .dest_id_o    (dest_id_o),
    .send_stamp_o (send_stamp_o),
    .granted_o    (granted_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

// File: src/dmnc_ctrl.sv
// ----------------------------------------------------------------------------
// dmnc_ctrl
// Sequencer: accepts an event, runs it, then walks deferred replies.
// ----------------------------------------------------------------------------
module dmnc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  dmnc_pkg::sts_t sts_i,
  output dmnc_pkg::cmd_t cmd_o
);

  dmnc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dmnc_pkg::StIdle: begin
        if (in_valid_i) state_d = dmnc_pkg::StExec;
      end
      dmnc_pkg::StExec: begin
        if (out_free) state_d = sts_i.rel_more ? dmnc_pkg::StWalk : dmnc_pkg::StIdle;
      end
      dmnc_pkg::StWalk: begin
        if (out_free && !sts_i.more) state_d = dmnc_pkg::StIdle;
      end
      default: state_d = dmnc_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      dmnc_pkg::StIdle: begin
        in_stall_o   = 1'b0;
        cmd_o.latch  = in_valid_i;
      end
      dmnc_pkg::StExec: cmd_o.exec = out_free;
      dmnc_pkg::StWalk: cmd_o.step = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec || cmd_o.step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmnc_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/dmnc_dp.sv
// ----------------------------------------------------------------------------
// dmnc_dp
// Node state, Lamport clock, deferred set and the result register.
// ----------------------------------------------------------------------------
module dmnc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dmnc_pkg::cmd_t                      cmd_i,
  output dmnc_pkg::sts_t                      sts_o,
  input  logic                                cfg_we_i,
  input  logic [dmnc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [dmnc_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic [1:0]                          op_i,
  input  logic [dmnc_pkg::IdW-1:0]            peer_id_i,
  input  logic [dmnc_pkg::StampW-1:0]         peer_stamp_i,
  output logic [1:0]                          send_kind_o,
  output logic [dmnc_pkg::IdW-1:0]            dest_id_o,
  output logic [dmnc_pkg::StampW-1:0]         send_stamp_o,
  output logic                                granted_o,
  output logic [1:0]                          status_o,
  output logic                                last_o
);

  // configuration
  logic [dmnc_pkg::HostCountW-1:0] host_count_q;
  logic [dmnc_pkg::IdW-1:0]        local_id_q;

  // latched event
  dmnc_pkg::op_e               op_q;
  logic [dmnc_pkg::IdW-1:0]    peer_q;
  logic [dmnc_pkg::StampW-1:0] stamp_q;

  // node state
  logic [dmnc_pkg::StampW-1:0]   clock_q, clock_d;
  logic [dmnc_pkg::StampW-1:0]   own_q, own_d;
  logic                          req_q, req_d;
  logic                          ins_q, ins_d;
  logic [dmnc_pkg::CountW-1:0]   rc_q, rc_d;
  logic [dmnc_pkg::MaxNodes-1:0] def_q, def_d;

  // result register
  dmnc_pkg::send_kind_e        kind_q, kind_d;
  logic [dmnc_pkg::IdW-1:0]    dest_q, dest_d;
  logic [dmnc_pkg::StampW-1:0] sstamp_q, sstamp_d;
  logic                        grant_q, grant_d;
  dmnc_pkg::status_e           stat_q, stat_d;
  logic                        last_q, last_d;

  logic [dmnc_pkg::HostCountW-1:0] hc_sat;
  logic [dmnc_pkg::HostCountW-1:0] needed;
  logic [dmnc_pkg::IdW-1:0]        low_idx;
  logic [dmnc_pkg::MaxNodes-1:0]   def_rest;
  logic                            more;
  logic [dmnc_pkg::StampW-1:0]     clk_adv;
  logic                            older;
  logic [dmnc_pkg::CountW-1:0]     rc_inc;

  assign hc_sat = (host_count_q > dmnc_pkg::HostCountW'(dmnc_pkg::MaxNodes))
                  ? dmnc_pkg::HostCountW'(dmnc_pkg::MaxNodes) : host_count_q;
  assign needed = (hc_sat < dmnc_pkg::HostCountW'(2)) ? '0
                  : hc_sat - dmnc_pkg::HostCountW'(1);

  always_comb begin
    low_idx = '0;
    for (int i = dmnc_pkg::MaxNodes - 1; i >= 0; i--) begin
      if (def_q[i]) low_idx = dmnc_pkg::IdW'(i);
    end
  end

  assign def_rest = def_q & (def_q - dmnc_pkg::MaxNodes'(1));
  assign more     = |def_rest;

  assign sts_o.more     = more;
  assign sts_o.rel_more = (op_q == dmnc_pkg::OpRelease) && ins_q && more;

  assign clk_adv = ((clock_q > stamp_q) ? clock_q : stamp_q) + dmnc_pkg::StampW'(1);
  assign older   = req_q && ((own_q < stamp_q) ||
                             ((own_q == stamp_q) && (local_id_q < peer_q)));
  assign rc_inc  = (rc_q < dmnc_pkg::CountMax) ? rc_q + dmnc_pkg::CountW'(1) : rc_q;

  always_comb begin
    clock_d  = clock_q;
    own_d    = own_q;
    req_d    = req_q;
    ins_d    = ins_q;
    rc_d     = rc_q;
    def_d    = def_q;
    kind_d   = kind_q;
    dest_d   = dest_q;
    sstamp_d = sstamp_q;
    grant_d  = grant_q;
    stat_d   = stat_q;
    last_d   = last_q;
    if (cmd_i.exec) begin
      kind_d   = dmnc_pkg::SendNone;
      dest_d   = '0;
      sstamp_d = '0;
      grant_d  = 1'b0;
      stat_d   = dmnc_pkg::StsOk;
      last_d   = 1'b1;
      case (op_q)
        dmnc_pkg::OpAcquire: begin
          if (req_q || ins_q) begin
            stat_d = dmnc_pkg::StsBadAcquire;
          end else begin
            own_d    = clock_q;
            rc_d     = '0;
            kind_d   = dmnc_pkg::SendBroadcast;
            sstamp_d = clock_q;
            if (needed == '0) begin
              ins_d   = 1'b1;
              grant_d = 1'b1;
            end else begin
              req_d = 1'b1;
            end
          end
        end
        dmnc_pkg::OpRelease: begin
          if (!ins_q) begin
            stat_d = dmnc_pkg::StsBadRelease;
          end else begin
            ins_d = 1'b0;
            req_d = 1'b0;
            rc_d  = '0;
            if (|def_q) begin
              kind_d   = dmnc_pkg::SendReply;
              dest_d   = low_idx;
              sstamp_d = clock_q;
              last_d   = !more;
              def_d    = def_rest;
            end
          end
        end
        dmnc_pkg::OpRequest: begin
          clock_d = clk_adv;
          if (ins_q || older) begin
            def_d[peer_q] = 1'b1;
          end else begin
            kind_d   = dmnc_pkg::SendReply;
            dest_d   = peer_q;
            sstamp_d = clk_adv;
          end
        end
        dmnc_pkg::OpReply: begin
          clock_d = clk_adv;
          if (req_q) begin
            rc_d = rc_inc;
            if ({1'b0, rc_inc} >= needed) begin
              ins_d   = 1'b1;
              req_d   = 1'b0;
              grant_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      kind_d   = dmnc_pkg::SendReply;
      dest_d   = low_idx;
      sstamp_d = clock_q;
      grant_d  = 1'b0;
      stat_d   = dmnc_pkg::StsOk;
      last_d   = !more;
      def_d    = def_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_count_q <= dmnc_pkg::HostCountRst;
      local_id_q   <= '0;
      clock_q      <= '0;
      own_q        <= '0;
      req_q        <= 1'b0;
      ins_q        <= 1'b0;
      rc_q         <= '0;
      def_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (dmnc_pkg::cfg_idx_e'(cfg_index_i))
          dmnc_pkg::CfgHostCount: host_count_q <= cfg_data_i;
          dmnc_pkg::CfgLocalId:   local_id_q   <= cfg_data_i[dmnc_pkg::IdW-1:0];
          default: ;
        endcase
      end
      clock_q <= clock_d;
      own_q   <= own_d;
      req_q   <= req_d;
      ins_q   <= ins_d;
      rc_q    <= rc_d;
      def_q   <= def_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= dmnc_pkg::op_e'(op_i);
      peer_q  <= peer_id_i;
      stamp_q <= peer_stamp_i;
    end
    kind_q   <= kind_d;
    dest_q   <= dest_d;
    sstamp_q <= sstamp_d;
    grant_q  <= grant_d;
    stat_q   <= stat_d;
    last_q   <= last_d;
  end

  assign send_kind_o  = kind_q;
  assign dest_id_o    = dest_q;
  assign send_stamp_o = sstamp_q;
  assign granted_o    = grant_q;
  assign status_o     = stat_q;
  assign last_o       = last_q;

endmodule

// File: verif/mutex_event_checker.sv
// ----------------------------------------------------------------------------
// mutex_event_checker
// Tracks the lock node's state from accepted events and config writes, keeps
// the results that each transfer should produce, and compares every output
// transfer field by field against the oldest one still waiting.
// ----------------------------------------------------------------------------
module mutex_event_checker
  import dmnc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [1:0]          op_i,
  input  logic [IdW-1:0]      peer_id_i,
  input  logic [StampW-1:0]   peer_stamp_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [1:0]          send_kind_i,
  input  logic [IdW-1:0]      dest_id_i,
  input  logic [StampW-1:0]   send_stamp_i,
  input  logic                granted_i,
  input  logic [1:0]          status_i,
  input  logic                last_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    send_kind_e        kind;
    logic [IdW-1:0]    dest;
    logic [StampW-1:0] stamp;
    logic              granted;
    status_e           status;
    logic              last;
  } node_msg_t;

  node_msg_t expected_msgs[$];

  logic [HostCountW-1:0] hosts;
  logic [IdW-1:0]        my_id;
  logic [StampW-1:0]     lclock;
  logic                  pending_req;
  logic                  holding;
  logic [StampW-1:0]     req_stamp;
  logic [CountW-1:0]     replies;
  logic [MaxNodes-1:0]   deferred;
  int unsigned           errors = 0;

  function automatic logic [HostCountW-1:0] replies_needed();
    logic [HostCountW-1:0] n;
    n = (hosts > MaxNodes) ? HostCountW'(MaxNodes) : hosts;
    return (n < 2) ? '0 : n - 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [StampW-1:0] want,
                             input logic [StampW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic predict_event(input op_e op, input logic [IdW-1:0] pid,
                               input logic [StampW-1:0] stamp);
    logic older;
    logic grant;
    case (op)
      OpAcquire: begin
        if (pending_req || holding) begin
          expected_msgs.push_back(node_msg_t'{SendNone, 4'd0, 32'd0, 1'b0, StsBadAcquire, 1'b1});
        end else begin
          req_stamp = lclock;
          replies = '0;
          grant = (replies_needed() == 0);
          holding = grant;
          pending_req = !grant;
          expected_msgs.push_back(node_msg_t'{SendBroadcast, 4'd0, req_stamp, grant, StsOk, 1'b1});
        end
      end
      OpRelease: begin
        if (!holding) begin
          expected_msgs.push_back(node_msg_t'{SendNone, 4'd0, 32'd0, 1'b0, StsBadRelease, 1'b1});
        end else begin
          holding = 1'b0;
          pending_req = 1'b0;
          replies = '0;
          if (deferred == '0) begin
            expected_msgs.push_back(node_msg_t'{SendNone, 4'd0, 32'd0, 1'b0, StsOk, 1'b1});
          end else begin
            // ascending id order, last flag on the highest deferred peer
            for (int i = 0; i < MaxNodes; i++) begin
              if (deferred[i]) begin
                deferred[i] = 1'b0;
                expected_msgs.push_back(node_msg_t'{SendReply, IdW'(i), lclock, 1'b0, StsOk,
                                                    deferred == '0});
              end
            end
          end
        end
      end
      OpRequest: begin
        lclock = ((lclock > stamp) ? lclock : stamp) + 1'b1;
        older = pending_req && (req_stamp < stamp || (req_stamp == stamp && my_id < pid));
        if (holding || older) begin
          deferred[pid] = 1'b1;
          expected_msgs.push_back(node_msg_t'{SendNone, 4'd0, 32'd0, 1'b0, StsOk, 1'b1});
        end else begin
          expected_msgs.push_back(node_msg_t'{SendReply, pid, lclock, 1'b0, StsOk, 1'b1});
        end
      end
      OpReply: begin
        lclock = ((lclock > stamp) ? lclock : stamp) + 1'b1;
        grant = 1'b0;
        if (pending_req) begin
          if (replies != CountMax) replies++;
          if (replies >= replies_needed()) begin
            holding = 1'b1;
            pending_req = 1'b0;
            grant = 1'b1;
          end
        end
        expected_msgs.push_back(node_msg_t'{SendNone, 4'd0, 32'd0, grant, StsOk, 1'b1});
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    node_msg_t want;
    if (!rst_ni) begin
      hosts = HostCountRst;
      my_id = '0;
      lclock = '0;
      pending_req = 1'b0;
      holding = 1'b0;
      req_stamp = '0;
      replies = '0;
      deferred = '0;
      expected_msgs.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_msgs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual kind %0d dest %0d stamp %0h",
                   $time, send_kind_i, dest_id_i, send_stamp_i);
        end else begin
          want = expected_msgs.pop_front();
          check_field("send_kind", want.kind, send_kind_i);
          check_field("dest_id", want.dest, dest_id_i);
          check_field("send_stamp", want.stamp, send_stamp_i);
          check_field("granted", want.granted, granted_i);
          check_field("status", want.status, status_i);
          check_field("last", want.last, last_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgHostCount: hosts = cfg_data_i;
          CfgLocalId:   my_id = cfg_data_i[IdW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_event(op_e'(op_i), peer_id_i, peer_stamp_i);
      end
    end
    fail_count_o <= errors;
    pending_o <= expected_msgs.size();
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives lock events and config writes into the mutex node controller under
// random sender gaps and receiver stalls: a directed pass over the corner
// cases, then full acquire/reply/release rounds mixed with random events
// across several host counts and ids. A side checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dmnc_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          op_i = OpAcquire;
  logic [IdW-1:0]      peer_id_i = '0;
  logic [StampW-1:0]   peer_stamp_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          send_kind_o;
  logic [IdW-1:0]      dest_id_o;
  logic [StampW-1:0]   send_stamp_o;
  logic                granted_o;
  logic [1:0]          status_o;
  logic                last_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgHostCount;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int unsigned       in_idle_pct = 9;
  int unsigned       out_idle_pct = 77;
  int unsigned       sent_count = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       host_plan [7] = '{31, 3, 16, 4, 2, 1, 3};
  logic [StampW-1:0] clock_hint = '0;
  logic [StampW-1:0] acq_hint = '0;

  always #6ns clk_i = ~clk_i;

  distributed_mutex_node_controller_top u_top (.*);

  mutex_event_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .op_i         (op_i),
    .peer_id_i    (peer_id_i),
    .peer_stamp_i (peer_stamp_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .send_kind_i  (send_kind_o),
    .dest_id_i    (dest_id_o),
    .send_stamp_i (send_stamp_o),
    .granted_i    (granted_o),
    .status_i     (status_o),
    .last_i       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one event transfer; the stamp hints only steer stimulus toward ties
  task automatic send_event(input op_e op, input logic [IdW-1:0] pid,
                            input logic [StampW-1:0] stamp);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    peer_id_i <= pid;
    peer_stamp_i <= stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
    if (op == OpRequest || op == OpReply) begin
      clock_hint = ((clock_hint > stamp) ? clock_hint : stamp) + 1'b1;
    end else if (op == OpAcquire) begin
      acq_hint = clock_hint;
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [HostCountW-1:0] hc, input logic [IdW-1:0] id);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgHostCount;
    cfg_data_i <= hc;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CfgLocalId;
    cfg_data_i <= CfgDataW'(id);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [StampW-1:0] pick_stamp(input logic [StampW-1:0] base);
    if ($urandom_range(7) == 0) return $urandom();
    return base + StampW'($urandom_range(4)) - StampW'(2);
  endfunction

  task automatic run_round(input int unsigned need);
    send_event(OpAcquire, IdW'($urandom_range(15)), $urandom());
    repeat ($urandom_range(3)) begin
      send_event(OpRequest, IdW'($urandom_range(15)), pick_stamp(acq_hint));
    end
    repeat (need) begin
      if ($urandom_range(3) == 0) begin
        send_event(OpRequest, IdW'($urandom_range(15)), pick_stamp(acq_hint));
      end
      send_event(OpReply, IdW'($urandom_range(15)), pick_stamp(clock_hint));
    end
    repeat ($urandom_range(2)) begin
      send_event(OpRequest, IdW'($urandom_range(15)), pick_stamp(clock_hint));
    end
    send_event(OpRelease, IdW'($urandom_range(15)), $urandom());
  endtask

  initial begin
    int unsigned need;
    int unsigned phase_start;
    int unsigned random_start;
    int unsigned r;
    logic [HostCountW-1:0] hc;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: two hosts, local id 0
    send_event(OpRelease, 4'd0, 32'd0);
    send_event(OpReply, 4'd0, 32'd0);
    send_event(OpRequest, 4'd15, 32'hFFFF_FFFF);
    send_event(OpAcquire, 4'd0, 32'd0);
    send_event(OpAcquire, 4'd15, 32'hFFFF_FFFF);
    send_event(OpRequest, 4'd3, 32'd0);
    send_event(OpRequest, 4'd0, 32'd0);
    send_event(OpRequest, 4'd5, 32'd100);
    send_event(OpReply, 4'd1, 32'd7);
    send_event(OpAcquire, 4'd0, 32'd0);
    send_event(OpRequest, 4'd9, 32'd2);
    send_event(OpRequest, 4'd10, 32'hFFFF_FFFE);
    send_event(OpRelease, 4'd0, 32'd0);
    send_event(OpRelease, 4'd0, 32'd0);

    // a lone host enters without replies
    wait_idle();
    configure(5'd1, 4'd15);
    send_event(OpAcquire, 4'd0, 32'd0);
    send_event(OpRequest, 4'd14, 32'd5);
    send_event(OpRelease, 4'd0, 32'd0);
    wait_idle();
    configure(5'd0, 4'd15);
    send_event(OpAcquire, 4'd0, 32'd0);
    send_event(OpRelease, 4'd0, 32'd0);

    // tie-break with the highest local id
    wait_idle();
    configure(5'd2, 4'd15);
    send_event(OpAcquire, 4'd0, 32'd0);
    send_event(OpRequest, 4'd4, acq_hint);
    send_event(OpRequest, 4'd6, acq_hint + 1'b1);
    send_event(OpRequest, 4'd2, acq_hint - 1'b1);
    send_event(OpReply, 4'd8, clock_hint);
    send_event(OpRelease, 4'd0, 32'd0);

    random_start = sent_count;
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      hc = HostCountW'(host_plan[p]);
      configure(hc, (p == 0) ? 4'd15 : (p == 2) ? 4'd0 : IdW'($urandom_range(15)));
      need = (hc > MaxNodes) ? MaxNodes - 1 : (hc < 2) ? 0 : hc - 1;
      phase_start = sent_count;
      while (sent_count - phase_start < 7) begin
        r = sent_count - random_start;
        in_idle_pct = (r < 37) ? 9 : (r < 74) ? 77 : 0;
        out_idle_pct = (r < 37) ? 77 : (r < 74) ? 9 : 0;
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_event(op_e'($urandom_range(3)), IdW'($urandom_range(15)),
                       pick_stamp(clock_hint));
          end
        end else begin
          run_round(need);
        end
      end
    end

    wait_idle();
    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
